FILE: hdl/mm4_pkg.sv
// ----------------------------------------------------------------------------
// mm4_pkg
// Shared constants, types and sequencer states of the 4x4 matrix multiplier.
// ----------------------------------------------------------------------------
package mm4_pkg;

  localparam int DIM_DEF        = 4;
  localparam int VALUE_BITS_DEF = 32;
  localparam int FRAC_BITS      = 16;
  localparam int ELEM_W         = 32;
  localparam int INDEX_W        = 2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT
  } mm4_state_t;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mm4_term_t;

endpackage

FILE: hdl/mm4_in_if.sv
// ----------------------------------------------------------------------------
// mm4_in_if
// Element load channel: one matrix element per transfer.
// ----------------------------------------------------------------------------
interface mm4_in_if
  import mm4_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic                      matrix_select;
  logic [INDEX_W-1:0]        row_index;
  logic [INDEX_W-1:0]        col_index;
  logic signed [ELEM_W-1:0]  element_value;
  logic                      compute_now;

  modport source (
    output valid, matrix_select, row_index, col_index, element_value, compute_now,
    input  ready
  );

  modport sink (
    input  valid, matrix_select, row_index, col_index, element_value, compute_now,
    output ready
  );
endinterface

FILE: hdl/mm4_out_if.sv
// ----------------------------------------------------------------------------
// mm4_out_if
// Product channel: one product element per transfer.
// ----------------------------------------------------------------------------
interface mm4_out_if
  import mm4_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic [INDEX_W-1:0]        out_row;
  logic [INDEX_W-1:0]        out_col;
  logic signed [ELEM_W-1:0]  product_value;
  logic                      last_result;

  modport source (
    output valid, out_row, out_col, product_value, last_result,
    input  ready
  );

  modport sink (
    input  valid, out_row, out_col, product_value, last_result,
    output ready
  );
endinterface

FILE: hdl/mm4_ram.sv
// ----------------------------------------------------------------------------
// mm4_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module mm4_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/mm4_mac.sv
// ----------------------------------------------------------------------------
// mm4_mac
// Multiply-accumulate datapath: registered product, wide accumulator,
// floor shift to Q16.16 and saturation.
// ----------------------------------------------------------------------------
module mm4_mac
  import mm4_pkg::*;
#(
  parameter int DIM        = DIM_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  mm4_term_t                    term,
  input  logic [VALUE_BITS-1:0]        first_data,
  input  logic [VALUE_BITS-1:0]        second_data,
  input  logic                         take,
  output logic                         acc_full,
  output logic signed [VALUE_BITS-1:0] acc_value
);

  localparam int PROD_W = 2 * VALUE_BITS;
  localparam int ACC_W  = PROD_W + $clog2(DIM) + 1;

  localparam logic signed [ACC_W-1:0] MAX_V =
    {{(ACC_W-VALUE_BITS+1){1'b0}}, {(VALUE_BITS-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] MIN_V = ~MAX_V;

  mm4_term_t                 s1_r;
  mm4_term_t                 s2_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [ACC_W-1:0]   acc_nxt;
  logic signed [ACC_W-1:0]   shifted;
  logic                      acc_full_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r       <= '0;
      s2_r       <= '0;
      acc_full_r <= 1'b0;
    end else begin
      s1_r <= term;
      s2_r <= s1_r;
      if (s2_r.valid && s2_r.last) begin
        acc_full_r <= 1'b1;
      end else if (take) begin
        acc_full_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= $signed(first_data) * $signed(second_data);
    if (s2_r.valid) begin
      acc_r <= acc_nxt;
    end
  end

  always_comb begin
    if (s2_r.first) begin
      acc_nxt = ACC_W'(prod_r);
    end else begin
      acc_nxt = acc_r + ACC_W'(prod_r);
    end
  end

  always_comb begin
    shifted = acc_r >>> FRAC_BITS;
    priority if (shifted > MAX_V) begin
      acc_value = MAX_V[VALUE_BITS-1:0];
    end else if (shifted < MIN_V) begin
      acc_value = MIN_V[VALUE_BITS-1:0];
    end else begin
      acc_value = shifted[VALUE_BITS-1:0];
    end
  end

  assign acc_full = acc_full_r;

endmodule

FILE: hdl/mm4_ctrl.sv
// ----------------------------------------------------------------------------
// mm4_ctrl
// Sequencer: drives the writes of loaded elements, walks the product cells
// and their terms, and holds the result register of the product channel.
// ----------------------------------------------------------------------------
module mm4_ctrl
  import mm4_pkg::*;
#(
  parameter int DIM        = DIM_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  mm4_in_if.sink                        in_ch,
  mm4_out_if.source                     out_ch,
  output logic                          we_first,
  output logic                          we_second,
  output logic [$clog2(DIM*DIM)-1:0]    wr_addr,
  output logic [VALUE_BITS-1:0]         wr_data,
  output logic [$clog2(DIM*DIM)-1:0]    rd_addr_first,
  output logic [$clog2(DIM*DIM)-1:0]    rd_addr_second,
  output mm4_term_t                     term,
  output logic                          take,
  input  logic                          acc_full,
  input  logic signed [VALUE_BITS-1:0]  acc_value
);

  localparam int IDX_W = $clog2(DIM);
  localparam int AW    = $clog2(DIM*DIM);
  localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(DIM - 1);

  mm4_state_t               state_r;
  mm4_state_t               state_nxt;
  logic [IDX_W-1:0]         r_r;
  logic [IDX_W-1:0]         c_r;
  logic [IDX_W-1:0]         k_r;
  logic                     out_valid_r;
  logic [INDEX_W-1:0]       out_row_r;
  logic [INDEX_W-1:0]       out_col_r;
  logic signed [ELEM_W-1:0] out_value_r;
  logic                     out_last_r;
  logic                     accept;
  logic                     in_range;
  logic                     cell_last;

  assign accept    = in_ch.valid && in_ch.ready;
  assign in_range  = (int'(in_ch.row_index) < DIM) && (int'(in_ch.col_index) < DIM);
  assign cell_last = (r_r == IDX_MAX) && (c_r == IDX_MAX);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && in_ch.compute_now) begin
          state_nxt = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (k_r == IDX_MAX) begin
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (take) begin
          state_nxt = cell_last ? ST_IDLE : ST_ISSUE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready    = 1'b0;
    term           = '0;
    take           = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
      end
      ST_ISSUE: begin
        term.valid = 1'b1;
        term.first = (k_r == '0);
        term.last  = (k_r == IDX_MAX);
      end
      ST_WAIT: begin
        take = acc_full && (!out_valid_r || out_ch.ready);
      end
      default: begin
        in_ch.ready = 1'b0;
      end
    endcase
  end

  assign we_first       = accept && in_range && !in_ch.matrix_select;
  assign we_second      = accept && in_range && in_ch.matrix_select;
  assign wr_addr        = AW'(int'(in_ch.row_index) * DIM + int'(in_ch.col_index));
  assign wr_data        = in_ch.element_value[VALUE_BITS-1:0];
  assign rd_addr_first  = AW'(int'(k_r) * DIM + int'(c_r));
  assign rd_addr_second = AW'(int'(r_r) * DIM + int'(k_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      r_r         <= '0;
      c_r         <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_IDLE) begin
        r_r <= '0;
        c_r <= '0;
        k_r <= '0;
      end else if (state_r == ST_ISSUE) begin
        k_r <= (k_r == IDX_MAX) ? '0 : k_r + 1'b1;
      end else if (take) begin
        if (c_r == IDX_MAX) begin
          c_r <= '0;
          r_r <= r_r + 1'b1;
        end else begin
          c_r <= c_r + 1'b1;
        end
      end
      if (take) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_row_r   <= INDEX_W'(r_r);
      out_col_r   <= INDEX_W'(c_r);
      out_value_r <= ELEM_W'(acc_value);
      out_last_r  <= cell_last;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.out_row       = out_row_r;
  assign out_ch.out_col       = out_col_r;
  assign out_ch.product_value = out_value_r;
  assign out_ch.last_result   = out_last_r;

endmodule

FILE: hdl/matrix4_multiply.sv
// ----------------------------------------------------------------------------
// matrix4_multiply
// Loads two DIM x DIM Q16.16 matrices element by element and, on request,
// streams their product result[r][c] = sum_k first[k][c] * second[r][k].
//
//   Channel   Dir  Transfer moves
//   in_ch     in   one element: matrix, row, column, value, compute flag
//   out_ch    out  one product element: row, column, value, last flag
//
// Loads are taken back to back while idle. A compute request then holds
// the block, output stalls included, until its last product is registered:
// each cell is DIM reads of the two element memories through one shared
// multiply-accumulate unit, then the read, product and accumulate registers fill.
// Reset is synchronous and active low; memory contents are not cleared.
// A stalled result holds in the output register while the next cell works.
// ----------------------------------------------------------------------------
module matrix4_multiply
  import mm4_pkg::*;
#(
  parameter int DIM        = DIM_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  mm4_in_if.sink    in_ch,
  mm4_out_if.source out_ch
);

  localparam int CELLS = DIM * DIM;
  localparam int AW    = $clog2(CELLS);

  logic                         we_first;
  logic                         we_second;
  logic [AW-1:0]                wr_addr;
  logic [VALUE_BITS-1:0]        wr_data;
  logic [AW-1:0]                rd_addr_first;
  logic [AW-1:0]                rd_addr_second;
  logic [VALUE_BITS-1:0]        first_data;
  logic [VALUE_BITS-1:0]        second_data;
  mm4_term_t                    term;
  logic                         take;
  logic                         acc_full;
  logic signed [VALUE_BITS-1:0] acc_value;

  mm4_ctrl #(
    .DIM        (DIM),
    .VALUE_BITS (VALUE_BITS)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .we_first       (we_first),
    .we_second      (we_second),
    .wr_addr        (wr_addr),
    .wr_data        (wr_data),
    .rd_addr_first  (rd_addr_first),
    .rd_addr_second (rd_addr_second),
    .term           (term),
    .take           (take),
    .acc_full       (acc_full),
    .acc_value      (acc_value)
  );

  mm4_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (CELLS)
  ) u_first_mem (
    .clk   (clk),
    .we    (we_first),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr_first),
    .rdata (first_data)
  );

  mm4_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (CELLS)
  ) u_second_mem (
    .clk   (clk),
    .we    (we_second),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr_second),
    .rdata (second_data)
  );

  mm4_mac #(
    .DIM        (DIM),
    .VALUE_BITS (VALUE_BITS)
  ) u_mac (
    .clk         (clk),
    .rst_n       (rst_n),
    .term        (term),
    .first_data  (first_data),
    .second_data (second_data),
    .take        (take),
    .acc_full    (acc_full),
    .acc_value   (acc_value)
  );

endmodule

FILE: hdl/matrix4_multiply_chk.sv
// ----------------------------------------------------------------------------
// matrix4_multiply_chk
// Port-level checks of the matrix multiplier, bound to the top level.
// ----------------------------------------------------------------------------
module matrix4_multiply_chk
  import mm4_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     in_compute_now,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [INDEX_W-1:0]       out_row,
  input logic [INDEX_W-1:0]       out_col,
  input logic signed [ELEM_W-1:0] out_value,
  input logic                     out_last
);

  // A stalled result keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_row) &&
      $stable(out_col) && $stable(out_last))
    else $error("stalled product changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("product offered right after reset");

  // While a product is being streamed, no new element is taken.
  a_busy_no_load: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("load taken during product stream");

  a_compute_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_compute_now |=> !in_ready)
    else $error("load taken right after compute request");

endmodule

bind matrix4_multiply matrix4_multiply_chk u_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .in_compute_now (in_ch.compute_now),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_row        (out_ch.out_row),
  .out_col        (out_ch.out_col),
  .out_value      (out_ch.product_value),
  .out_last       (out_ch.last_result)
);

FILE: tb/sv/matrix4_multiply_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// matrix4_multiply_tb
// Loads Q16.16 elements into both operand matrices and checks every product
// element, field by field, against a local prediction of the 4x4 product.
// It first runs a short directed set for the saturation corners and the
// smallest negative step. Random loads follow, mostly full reloads in shuffled
// order that end in a compute. Both sides insert random gaps, and there is one
// long output hold-off and one full drain.
// ----------------------------------------------------------------------------
module matrix4_multiply_tb;
  import mm4_pkg::*;

  localparam int CELLS       = DIM_DEF * DIM_DEF;
  localparam int RANDOM_LOADS = 270;
  localparam int LONG_HOLD   = 300;
  localparam int QUIET_LIMIT = 2000;
  localparam int TAIL_CYCLES = CELLS * (DIM_DEF + 3) + 20;

  typedef struct {
    bit                       sel;
    logic [INDEX_W-1:0]       row;
    logic [INDEX_W-1:0]       col;
    logic signed [ELEM_W-1:0] value;
    bit                       go;
  } load_t;

  typedef struct {
    logic [INDEX_W-1:0]       row;
    logic [INDEX_W-1:0]       col;
    logic signed [ELEM_W-1:0] value;
    logic                     last;
  } product_t;

  class mm4_product_board;
    logic signed [ELEM_W-1:0] first_m[CELLS];
    logic signed [ELEM_W-1:0] second_m[CELLS];
    product_t                 awaited[$];
    int                       errors = 0;

    function logic signed [ELEM_W-1:0] product_cell(int r, int c);
      logic signed [67:0] acc;
      logic signed [67:0] term;
      int k;
      acc = '0;
      for (k = 0; k < DIM_DEF; k++) begin
        term = first_m[k * DIM_DEF + c] * second_m[r * DIM_DEF + k];
        acc = acc + term;
      end
      acc = acc >>> FRAC_BITS;
      if (acc > 68'sd2147483647) return 32'sh7FFFFFFF;
      if (acc < -68'sd2147483648) return 32'sh80000000;
      return acc[ELEM_W-1:0];
    endfunction

    function void note_load(load_t ld);
      product_t p;
      int r;
      int c;
      if (ld.sel) second_m[ld.row * DIM_DEF + ld.col] = ld.value;
      else first_m[ld.row * DIM_DEF + ld.col] = ld.value;
      if (ld.go) begin
        for (r = 0; r < DIM_DEF; r++) begin
          for (c = 0; c < DIM_DEF; c++) begin
            p.row   = r[INDEX_W-1:0];
            p.col   = c[INDEX_W-1:0];
            p.value = product_cell(r, c);
            p.last  = (r == DIM_DEF - 1) && (c == DIM_DEF - 1);
            awaited.push_back(p);
          end
        end
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_product(product_t got);
      product_t want;
      if (awaited.size() == 0) begin
        report($sformatf("unexpected product row %0d col %0d value %h",
                         got.row, got.col, got.value));
      end else begin
        want = awaited.pop_front();
        if (got.row !== want.row)
          report($sformatf("row %0d, expected %0d", got.row, want.row));
        if (got.col !== want.col)
          report($sformatf("col %0d, expected %0d", got.col, want.col));
        if (got.value !== want.value)
          report($sformatf("cell %0d,%0d value %h, expected %h",
                           want.row, want.col, got.value, want.value));
        if (got.last !== want.last)
          report($sformatf("cell %0d,%0d last %b, expected %b",
                           want.row, want.col, got.last, want.last));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   loads_sent = 0;
  int   quiet_cycles = 0;

  mm4_product_board board = new();

  mm4_in_if  in_ch();
  mm4_out_if out_ch();

  matrix4_multiply u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  function automatic load_t mk_load(int sel, int row, int col, logic [31:0] value, bit go);
    load_t ld;
    ld.sel   = sel[0];
    ld.row   = row[INDEX_W-1:0];
    ld.col   = col[INDEX_W-1:0];
    ld.value = value;
    ld.go    = go;
    return ld;
  endfunction

  function automatic logic [31:0] pick_value();
    logic signed [31:0] v;
    int sh;
    v = $urandom();
    case ($urandom_range(0, 4))
      0: return v;
      1: begin
        case ($urandom_range(0, 5))
          0: return 32'h7FFFFFFF;
          1: return 32'h80000000;
          2: return 32'h00010000;
          3: return 32'hFFFF0000;
          4: return 32'hFFFFFFFF;
          default: return 32'h00000000;
        endcase
      end
      default: begin
        sh = $urandom_range(1, 30);
        v = v <<< sh;
        v = v >>> sh;
        return v;
      end
    endcase
  endfunction

  function automatic int load_gap(int n);
    if ((n >= 60 && n < 100) || (n >= 220 && n < 260)) return 0;
    return $urandom_range(0, 18);
  endfunction

  task automatic send_load(load_t ld);
    int gap;
    gap = load_gap(loads_sent);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.matrix_select <= ld.sel;
    in_ch.row_index     <= ld.row;
    in_ch.col_index     <= ld.col;
    in_ch.element_value <= ld.value;
    in_ch.compute_now   <= ld.go;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    board.note_load(ld);
    loads_sent++;
  endtask

  initial begin : load_source
    int  i;
    int  j;
    int  t;
    int  rand_sent;
    bit  drained;
    int  order[2 * CELLS];
    in_ch.valid         <= 1'b0;
    in_ch.matrix_select <= 1'b0;
    in_ch.row_index     <= '0;
    in_ch.col_index     <= '0;
    in_ch.element_value <= '0;
    in_ch.compute_now   <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // All elements at the positive maximum: every product saturates high.
    for (i = 0; i < 2 * CELLS; i++)
      send_load(mk_load(i / CELLS, (i / DIM_DEF) % DIM_DEF, i % DIM_DEF,
                        32'h7FFFFFFF, i == 2 * CELLS - 1));
    // Row 0 of the second matrix at the minimum: row 0 saturates low.
    for (i = 0; i < DIM_DEF; i++)
      send_load(mk_load(1, 0, i, 32'h80000000, i == DIM_DEF - 1));
    // Smallest negative step, and a load that computes nothing.
    send_load(mk_load(0, 0, 0, 32'hFFFFFFFF, 1));
    send_load(mk_load(0, 3, 3, 32'h00000000, 0));
    send_load(mk_load(1, 3, 3, 32'hFFFF0000, 1));

    rand_sent = 0;
    drained = 0;
    while (rand_sent < RANDOM_LOADS) begin
      if (!drained && rand_sent >= 150) begin
        drained = 1;
        if (board.pending() != 0) begin
          in_ch.valid <= 1'b0;
          while (board.pending() != 0) @(posedge clk);
        end
      end
      if ($urandom_range(0, 2) != 0) begin
        for (i = 0; i < 2 * CELLS; i++) order[i] = i;
        for (i = 2 * CELLS - 1; i > 0; i--) begin
          j = $urandom_range(0, i);
          t = order[i];
          order[i] = order[j];
          order[j] = t;
        end
        for (i = 0; i < 2 * CELLS; i++)
          send_load(mk_load(order[i] / CELLS, (order[i] / DIM_DEF) % DIM_DEF,
                            order[i] % DIM_DEF, pick_value(), i == 2 * CELLS - 1));
        rand_sent += 2 * CELLS;
      end else begin
        send_load(mk_load($urandom_range(0, 1), $urandom_range(0, DIM_DEF - 1),
                          $urandom_range(0, DIM_DEF - 1), pick_value(),
                          $urandom_range(0, 5) == 0));
        rand_sent++;
      end
    end
    in_ch.valid <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("PASS matrix4_multiply");
    end else begin
      $display("FAIL matrix4_multiply");
    end
    $finish;
  end

  initial begin : product_sink
    int       stall;
    int       seen;
    product_t got;
    out_ch.ready <= 1'b0;
    seen = 0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (seen == 40) stall = LONG_HOLD;
      else if (seen >= 200 && seen < 300) stall = 0;
      else stall = $urandom_range(0, 18);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      got.row   = out_ch.out_row;
      got.col   = out_ch.out_col;
      got.value = out_ch.product_value;
      got.last  = out_ch.last_result;
      board.check_product(got);
      seen++;
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL matrix4_multiply");
      $finish;
    end
  end

endmodule
